// ----- sv/symbol_deque_with_membership_assert.svh -----
// Assertion macros for the symbol deque RTL.
// Included by modules that carry concurrent checks; no other dependencies.
`ifndef SYMBOL_DEQUE_WITH_MEMBERSHIP_ASSERT_SVH
`define SYMBOL_DEQUE_WITH_MEMBERSHIP_ASSERT_SVH

// Same-cycle implication, disabled while reset is asserted.
`define SDQ_ASSERT_NOW(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication, disabled while reset is asserted.
`define SDQ_ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |=> (cons)) \
        else $error(msg);

`endif

// ----- sv/sdq_pkg.sv -----
// Shared types and codes for the symbol deque.
// No dependencies; used by the controller, datapath and top level.
`timescale 1ns / 1ps

package sdq_pkg;

    localparam int OP_W     = 3;
    localparam int SYM_W    = 8;
    localparam int COUNT_W  = 5;
    localparam int STATUS_W = 2;

    localparam logic [OP_W-1:0] OP_PUSH_FRONT    = 3'd0;
    localparam logic [OP_W-1:0] OP_PUSH_BACK     = 3'd1;
    localparam logic [OP_W-1:0] OP_REPLACE_FRONT = 3'd2;
    localparam logic [OP_W-1:0] OP_REPLACE_BACK  = 3'd3;
    localparam logic [OP_W-1:0] OP_QUERY         = 3'd4;

    localparam logic [STATUS_W-1:0] ST_DONE  = 2'd0;
    localparam logic [STATUS_W-1:0] ST_FULL  = 2'd1;
    localparam logic [STATUS_W-1:0] ST_EMPTY = 2'd2;

    // controller -> datapath
    typedef struct packed {
        logic load;    // capture request
        logic exec;    // apply push/overwrite, or arm the search
        logic scan;    // issue one storage read of the search
        logic finish;  // close the search and reply
    } t_ctl_cmd;

    // datapath -> controller
    typedef struct packed {
        logic scan_go;    // registered request is a query on a non-empty queue
        logic scan_last;  // current read is of the back element
    } t_dp_sts;

endpackage

// ----- sv/sdq_ram.sv -----
// Generic single-write, single-read RAM with registered read data.
// No dependencies.
`timescale 1ns / 1ps

module sdq_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic                     i_re,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        if (i_re) begin
            r_rdata <= r_mem[i_raddr];
        end
    end

    assign o_rdata = r_rdata;

endmodule

// ----- sv/sdq_ctl.sv -----
// Request sequencer for the symbol deque.
// Depends on sdq_pkg for the command and status structs.
`timescale 1ns / 1ps

module sdq_ctl (
    input  logic            i_clk,
    input  logic            i_rst_n,
    input  logic            i_start,
    output logic            o_busy,
    output sdq_pkg::t_ctl_cmd o_cmd,
    input  sdq_pkg::t_dp_sts  i_sts
);

    localparam logic [1:0] S_IDLE  = 2'd0;
    localparam logic [1:0] S_EXEC  = 2'd1;
    localparam logic [1:0] S_SCAN  = 2'd2;
    localparam logic [1:0] S_DRAIN = 2'd3;

    logic [1:0] r_state;
    logic [1:0] n_state;

    always_comb begin
        n_state = r_state;
        o_cmd   = '0;
        case (r_state)
            S_IDLE: begin
                o_cmd.load = i_start;
                if (i_start) begin
                    n_state = S_EXEC;
                end
            end
            S_EXEC: begin
                o_cmd.exec = 1'b1;
                n_state    = i_sts.scan_go ? S_SCAN : S_IDLE;
            end
            S_SCAN: begin
                o_cmd.scan = 1'b1;
                if (i_sts.scan_last) begin
                    n_state = S_DRAIN;
                end
            end
            S_DRAIN: begin
                o_cmd.finish = 1'b1;
                n_state      = S_IDLE;
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    assign o_busy = (r_state != S_IDLE);

endmodule

// ----- sv/sdq_dp.sv -----
// Datapath of the symbol deque: ring pointers, storage RAM, search and reply registers.
// Depends on sdq_pkg, sdq_ram and the assertion macro header.
`timescale 1ns / 1ps
`include "symbol_deque_with_membership_assert.svh"

module sdq_dp #(
    parameter int DEPTH = 16
) (
    input  logic                            i_clk,
    input  logic                            i_rst_n,
    input  sdq_pkg::t_ctl_cmd               i_cmd,
    output sdq_pkg::t_dp_sts                o_sts,
    input  logic [sdq_pkg::OP_W-1:0]        i_operation,
    input  logic [sdq_pkg::SYM_W-1:0]       i_symbol,
    output logic                            o_valid,
    output logic                            o_found,
    output logic [sdq_pkg::COUNT_W-1:0]     o_count,
    output logic [sdq_pkg::STATUS_W-1:0]    o_status
);

    localparam int IW = $clog2(DEPTH);
    localparam int CW = $clog2(DEPTH + 1);

    // request registers
    logic [sdq_pkg::OP_W-1:0]  r_op;
    logic [sdq_pkg::SYM_W-1:0] r_sym;

    // deque state
    logic [IW-1:0] r_front, n_front;
    logic [CW-1:0] r_count, n_count;

    // search state
    logic [IW-1:0] r_scan_idx;
    logic          r_rd_pend;
    logic          r_hit;

    // reply registers
    logic                         r_valid;
    logic                         r_found;
    logic [sdq_pkg::COUNT_W-1:0]  r_count_out;
    logic [sdq_pkg::STATUS_W-1:0] r_status;

    logic                         full, empty, match, reply;
    logic [IW-1:0]                front_dec;
    logic                         ram_we;
    logic [IW-1:0]                ram_waddr, ram_raddr;
    logic [sdq_pkg::SYM_W-1:0]    ram_rdata;
    logic [sdq_pkg::STATUS_W-1:0] n_status;

    // base + off modulo DEPTH; both operands below DEPTH
    function automatic logic [IW-1:0] ring_pos(input logic [IW-1:0] base,
                                               input logic [IW-1:0] off);
        logic [IW:0] sum;
        sum = {1'b0, base} + {1'b0, off};
        if (sum >= (IW+1)'(DEPTH)) begin
            sum = sum - (IW+1)'(DEPTH);
        end
        return sum[IW-1:0];
    endfunction

    always_comb begin
        full      = (r_count == CW'(DEPTH));
        empty     = (r_count == '0);
        front_dec = (r_front == '0) ? IW'(DEPTH - 1) : r_front - IW'(1);

        o_sts.scan_go   = (r_op == sdq_pkg::OP_QUERY) && !empty;
        o_sts.scan_last = ((CW'(r_scan_idx) + CW'(1)) == r_count);

        n_front   = r_front;
        n_count   = r_count;
        n_status  = sdq_pkg::ST_DONE;
        ram_we    = 1'b0;
        ram_waddr = r_front;

        case (r_op)
            sdq_pkg::OP_PUSH_FRONT: begin
                if (full) begin
                    n_status = sdq_pkg::ST_FULL;
                end else begin
                    ram_we    = 1'b1;
                    ram_waddr = front_dec;
                    n_front   = front_dec;
                    n_count   = r_count + CW'(1);
                end
            end
            sdq_pkg::OP_PUSH_BACK: begin
                if (full) begin
                    n_status = sdq_pkg::ST_FULL;
                end else begin
                    ram_we    = 1'b1;
                    ram_waddr = ring_pos(r_front, r_count[IW-1:0]);
                    n_count   = r_count + CW'(1);
                end
            end
            sdq_pkg::OP_REPLACE_FRONT: begin
                if (empty) begin
                    n_status = sdq_pkg::ST_EMPTY;
                end else begin
                    ram_we = 1'b1;
                end
            end
            sdq_pkg::OP_REPLACE_BACK: begin
                if (empty) begin
                    n_status = sdq_pkg::ST_EMPTY;
                end else begin
                    ram_we    = 1'b1;
                    ram_waddr = ring_pos(r_front, IW'(r_count - CW'(1)));
                end
            end
            default: begin
                // query and unused codes change nothing
            end
        endcase

        // only the exec step commits
        if (!i_cmd.exec) begin
            ram_we  = 1'b0;
            n_front = r_front;
            n_count = r_count;
        end

        ram_raddr = ring_pos(r_front, r_scan_idx);
        match     = r_rd_pend && (ram_rdata == r_sym);
        reply     = (i_cmd.exec && !o_sts.scan_go) || i_cmd.finish;
    end

    sdq_ram #(
        .WIDTH (sdq_pkg::SYM_W),
        .DEPTH (DEPTH)
    ) u_ram (
        .i_clk   (i_clk),
        .i_we    (ram_we),
        .i_waddr (ram_waddr),
        .i_wdata (r_sym),
        .i_re    (i_cmd.scan),
        .i_raddr (ram_raddr),
        .o_rdata (ram_rdata)
    );

    always_ff @(posedge i_clk) begin
        if (i_cmd.load) begin
            r_op  <= i_operation;
            r_sym <= i_symbol;
        end
        if (reply) begin
            r_found     <= i_cmd.finish & (r_hit | match);
            r_count_out <= sdq_pkg::COUNT_W'(n_count);
            r_status    <= i_cmd.finish ? sdq_pkg::ST_DONE : n_status;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_front    <= '0;
            r_count    <= '0;
            r_scan_idx <= '0;
            r_rd_pend  <= 1'b0;
            r_hit      <= 1'b0;
            r_valid    <= 1'b0;
        end else begin
            r_front   <= n_front;
            r_count   <= n_count;
            r_rd_pend <= i_cmd.scan;
            r_valid   <= reply;
            if (i_cmd.exec) begin
                r_scan_idx <= '0;
                r_hit      <= 1'b0;
            end else if (i_cmd.scan) begin
                r_scan_idx <= r_scan_idx + IW'(1);
                r_hit      <= r_hit | match;
            end
        end
    end

    assign o_valid  = r_valid;
    assign o_found  = r_found;
    assign o_count  = r_count_out;
    assign o_status = r_status;

    `SDQ_ASSERT_NOW(a_count_bound, i_clk, i_rst_n, 1'b1, r_count <= CW'(DEPTH), "count above depth")
    `SDQ_ASSERT_NOW(a_scan_in_range, i_clk, i_rst_n, i_cmd.scan, r_scan_idx < r_count, "scan past back")
    `SDQ_ASSERT_NEXT(a_reply_strobe, i_clk, i_rst_n, reply, r_valid, "reply not strobed")
    `SDQ_ASSERT_NOW(a_full_reply, i_clk, i_rst_n, r_valid && (r_status == sdq_pkg::ST_FULL), r_count == CW'(DEPTH), "full status on non-full queue")

endmodule

// ----- sv/symbol_deque_with_membership.sv -----
// Bounded double-ended queue of 8-bit symbols with push and overwrite at either end and a
// membership search. A request is taken when start is high and busy is low; its reply
// appears on o_found/o_count/o_status for exactly one cycle with o_valid high and cannot
// be held off, so the receiver must sample it then. A push or overwrite is captured, then
// commits in the exec state and registers its reply as busy drops; the next request can be
// taken while that reply shows. A membership query reads the held elements one per cycle
// through the single read port of the storage RAM and replies from the drain state (from
// the exec state on an empty queue). No clearing pass is needed after reset.
// Depends on sdq_pkg, sdq_ctl and sdq_dp.
`timescale 1ns / 1ps

module symbol_deque_with_membership #(
    parameter int DEPTH = 16
) (
    input  logic                         i_clk,
    input  logic                         i_rst_n,
    input  logic                         start,
    output logic                         busy,
    input  logic [sdq_pkg::OP_W-1:0]     i_operation,
    input  logic [sdq_pkg::SYM_W-1:0]    i_symbol,
    output logic                         o_valid,
    output logic                         o_found,
    output logic [sdq_pkg::COUNT_W-1:0]  o_count,
    output logic [sdq_pkg::STATUS_W-1:0] o_status
);

    sdq_pkg::t_ctl_cmd cmd;
    sdq_pkg::t_dp_sts  sts;

    sdq_ctl u_ctl (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_start (start),
        .o_busy  (busy),
        .o_cmd   (cmd),
        .i_sts   (sts)
    );

    sdq_dp #(
        .DEPTH (DEPTH)
    ) u_dp (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cmd       (cmd),
        .o_sts       (sts),
        .i_operation (i_operation),
        .i_symbol    (i_symbol),
        .o_valid     (o_valid),
        .o_found     (o_found),
        .o_count     (o_count),
        .o_status    (o_status)
    );

endmodule
